FILE: design/double_ended_queue_engine_top_defines.svh
// double_ended_queue_engine_top_defines.svh: assertion macros for the deque engine checker
// no dependencies; included by the checker file
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_TOP_DEFINES_SVH

// concurrent assertion, quiet while reset is high
`define DQE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define DQE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/dqe_pkg.sv
// dqe_pkg.sv: beat types, operation and status codes, default sizes for the deque engine
// no dependencies; used by the top level and the checker
package dqe_pkg;

  // field widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // default sizes
  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

endpackage

FILE: design/double_ended_queue_engine_top.sv
// double_ended_queue_engine_top.sv: double-ended queue of words held in a ring memory
// depends on dqe_pkg
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid, req_stall | dqe_pkg::req_t (operation, push_value)
//   rsp     | out       | rsp_valid, rsp_stall | dqe_pkg::rsp_t (result_value, status, occupancy)
//
// pushes, refused operations and unknown codes load the output register directly; a pop or peek
// that finds data first does a registered read of the word memory (S_READ), then loads the output register.
// every request beat yields exactly one response beat, held in an output register.
// reset clears front index, count and handshake state; memory contents stay undefined.
// a stalled response blocks new requests until it is taken (or taken in the same cycle).
module double_ended_queue_engine_top #(
  parameter int CAPACITY  = dqe_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = dqe_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dqe_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dqe_pkg::rsp_t rsp
);
  import dqe_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     front;
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     front_next;
  logic [CNT_W-1:0]     count_next;
  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data;
  logic [OCC_W-1:0]     rd_occ;

  logic                 out_free;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [IDX_W-1:0]     front_dec;
  logic [IDX_W-1:0]     front_inc;
  logic [IDX_W:0]       tail_sum;
  logic [IDX_W-1:0]     tail_slot;
  logic [IDX_W-1:0]     last_slot;
  logic [WORD_BITS-1:0] push_word;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_idx;
  logic [STATUS_W-1:0]  imm_status;
  logic [WORD_BITS-1:0] imm_value;

  // handshake: one beat in flight, output register must be free or draining
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;

  // ring index arithmetic
  assign full      = (count == CAP_CNT);
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign tail_sum  = {1'b0, front} + (IDX_W + 1)'(count);
  assign tail_slot = (tail_sum >= CAP_SUM) ? IDX_W'(tail_sum - CAP_SUM) : IDX_W'(tail_sum);
  assign last_slot = (tail_slot == '0) ? LAST_IDX : tail_slot - 1'b1;
  assign push_word = WORD_BITS'(req.push_value);

  // operation decode and next index/count
  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_idx     = tail_slot;
    rd_en      = 1'b0;
    rd_idx     = front;
    imm_status = STATUS_OK;
    imm_value  = '0;
    if (accept) begin
      case (req.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            imm_status = STATUS_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
            imm_value  = push_word;
            if (req.operation == OP_PUSH_FRONT) begin
              front_next = front_dec;
              wr_idx     = front_dec;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
          if (empty) begin
            imm_status = STATUS_EMPTY;
          end else begin
            rd_en = 1'b1;
            if (req.operation == OP_POP_BACK || req.operation == OP_PEEK_BACK) begin
              rd_idx = last_slot;
            end
            if (req.operation == OP_POP_FRONT) begin
              front_next = front_inc;
              count_next = count - 1'b1;
            end else if (req.operation == OP_POP_BACK) begin
              count_next = count - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // word memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= push_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
      rd_occ  <= OCC_W'(count_next);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      case (state)
        S_IDLE: begin
          if (accept && rd_en) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if ((accept && !rd_en) || (state == S_READ && out_free)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response beat register
  always_ff @(posedge clk) begin
    if (accept && !rd_en) begin
      rsp.result_value <= VALUE_W'(imm_value);
      rsp.status       <= imm_status;
      rsp.occupancy    <= OCC_W'(count_next);
    end else if (state == S_READ && out_free) begin
      rsp.result_value <= VALUE_W'(rd_data);
      rsp.status       <= STATUS_OK;
      rsp.occupancy    <= rd_occ;
    end
  end

endmodule

FILE: design/dqe_checker.sv
// dqe_checker.sv: port-level checks on the deque engine response channel, bound to the top level
// depends on dqe_pkg and double_ended_queue_engine_top_defines.svh
`include "double_ended_queue_engine_top_defines.svh"

module dqe_checker #(
  parameter int CAPACITY = dqe_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input dqe_pkg::rsp_t rsp
);
  import dqe_pkg::*;

  localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

  // no response beat right after reset
  `DQE_ASSERT_ALWAYS(a_rsp_idle_after_rst, clk, $past(rst) |-> !rsp_valid, "response valid after reset")

  // refused operations carry a zero word
  `DQE_ASSERT(a_refused_zero, clk, rst, rsp_valid && rsp.status != STATUS_OK |-> rsp.result_value == '0, "nonzero word on refused operation")

  // full status only with all entries taken
  `DQE_ASSERT(a_full_occ, clk, rst, rsp_valid && rsp.status == STATUS_FULL |-> rsp.occupancy == CAP_OCC, "full status with queue not full")

  // empty status only with no entries
  `DQE_ASSERT(a_empty_occ, clk, rst, rsp_valid && rsp.status == STATUS_EMPTY |-> rsp.occupancy == '0, "empty status with queue not empty")

  // stalled response beat holds
  `DQE_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response beat changed")

endmodule

bind double_ended_queue_engine_top dqe_checker #(.CAPACITY(CAPACITY)) u_dqe_checker (.*);
